// ===== sv/dqg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqg_pkg
// Shared types and constants of the dithered Q15 gain block: item kinds,
// queue entry layout, back-end stage layout and noise generator constants.
// ----------------------------------------------------------------------------
package dqg_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_MUTE  = 2'd0;
   localparam kind_type KIND_UNITY = 2'd1;
   localparam kind_type KIND_SCALE = 2'd2;

   localparam logic [31:0] NOISE_SEED    = 32'h5EED_1234;
   localparam logic [16:0] DITHER_OFFSET = 17'd32767;
   localparam logic [15:0] UNITY_GAIN    = 16'd32768;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] sample;
      logic [14:0]        gain;
      logic signed [16:0] dither;
      logic               last;
   } entry_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] product;
      logic signed [15:0] sample;
      logic signed [16:0] dither;
      logic               last;
   } stage_type;

   // One xorshift32 step with shifts 13, 17 and 5.
   function automatic logic [31:0] xs32_next(input logic [31:0] x);
      logic [31:0] t;
      t = x ^ (x << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
   endfunction

endpackage

// ===== sv/dqg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqg_front
// Classifies each item as mute, unity or scaled, draws TPDF dither for scaled
// items while enabled and keeps the dither enable and noise generator state.
// ----------------------------------------------------------------------------
module dqg_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                push,
   input  logic signed [15:0]  sample_in,
   input  logic [15:0]         gain,
   input  logic                last_in_buffer,
   output dqg_pkg::entry_type  entry
);

   logic               dither_en_ff;
   logic               dither_en_in;
   logic [31:0]        noise_ff;
   logic [31:0]        noise_in;
   logic [31:0]        draw_a;
   logic [31:0]        draw_b;
   logic signed [16:0] tpdf;
   dqg_pkg::kind_type  kind;
   logic               draw;

   always_comb begin
      priority if (gain == 16'd0) begin
         kind = dqg_pkg::KIND_MUTE;
      end else if (gain >= dqg_pkg::UNITY_GAIN) begin
         // Gains above unity are clamped to unity.
         kind = dqg_pkg::KIND_UNITY;
      end else begin
         kind = dqg_pkg::KIND_SCALE;
      end
   end

   assign draw_a = dqg_pkg::xs32_next(noise_ff);
   assign draw_b = dqg_pkg::xs32_next(draw_a);
   assign tpdf   = signed'({2'b00, draw_a[14:0]} + {2'b00, draw_b[14:0]}
                           - dqg_pkg::DITHER_OFFSET);

   assign draw = push && dither_en_ff && (kind == dqg_pkg::KIND_SCALE);

   assign noise_in     = draw ? draw_b : noise_ff;
   assign dither_en_in = csr_wr_en ? csr_wr_data : dither_en_ff;

   always_comb begin
      entry.kind   = kind;
      entry.sample = sample_in;
      entry.gain   = gain[14:0];
      entry.dither = dither_en_ff ? tpdf : 17'sd0;
      entry.last   = last_in_buffer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff     <= dqg_pkg::NOISE_SEED;
         dither_en_ff <= 1'b1;
      end else begin
         noise_ff     <= noise_in;
         dither_en_ff <= dither_en_in;
      end
   end

endmodule

// ===== sv/dqg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqg_queue
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module dqg_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  dqg_pkg::entry_type                  push_entry,
   input  logic                                pop,
   output dqg_pkg::entry_type                  head_entry,
   output logic                                empty,
   output logic                                full,
   output logic [dqg_pkg::QUEUE_CNT_W-1:0]     count
);

   dqg_pkg::entry_type                  slots_ff [dqg_pkg::QUEUE_DEPTH];
   logic [dqg_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [dqg_pkg::QUEUE_PTR_W-1:0]     wr_ptr_in;
   logic [dqg_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [dqg_pkg::QUEUE_PTR_W-1:0]     rd_ptr_in;
   logic [dqg_pkg::QUEUE_CNT_W-1:0]     count_ff;
   logic [dqg_pkg::QUEUE_CNT_W-1:0]     count_in;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == dqg_pkg::QUEUE_CNT_W'(dqg_pkg::QUEUE_DEPTH));
   assign count      = count_ff;
   assign head_entry = slots_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/dqg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqg_back
// Two-stage datapath: multiply, then add dither, shift by 15 with floor and
// saturate into the output register; mute gives zero, unity the sample.
// ----------------------------------------------------------------------------
module dqg_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  dqg_pkg::entry_type  head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_sample_out,
   output logic                rsp_last_out
);

   logic                 mul_valid_ff;
   logic                 mul_valid_in;
   dqg_pkg::stage_type   mul_ff;
   dqg_pkg::stage_type   mul_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic signed [15:0]   out_sample_ff;
   logic signed [15:0]   out_sample_in;
   logic                 out_last_ff;
   logic                 adv_out;
   logic                 adv_mul;
   logic signed [31:0]   sum;
   logic signed [16:0]   shifted;
   logic signed [15:0]   clamped;

   assign adv_out = !out_valid_ff || !rsp_stall;
   assign adv_mul = !mul_valid_ff || adv_out;
   assign pop     = head_valid && adv_mul;

   always_comb begin
      mul_in.kind    = head_entry.kind;
      mul_in.product = head_entry.sample * signed'({1'b0, head_entry.gain});
      mul_in.sample  = head_entry.sample;
      mul_in.dither  = head_entry.dither;
      mul_in.last    = head_entry.last;
   end

   assign mul_valid_in = adv_mul ? head_valid : mul_valid_ff;

   // Taking the upper bits of the sum is an arithmetic shift, which floors.
   assign sum     = mul_ff.product + 32'(mul_ff.dither);
   assign shifted = sum[31:15];

   always_comb begin
      if (shifted[16] != shifted[15]) begin
         clamped = shifted[16] ? 16'sh8000 : 16'sh7FFF;
      end else begin
         clamped = shifted[15:0];
      end
   end

   always_comb begin
      unique case (mul_ff.kind)
         dqg_pkg::KIND_MUTE:  out_sample_in = 16'sd0;
         dqg_pkg::KIND_UNITY: out_sample_in = mul_ff.sample;
         dqg_pkg::KIND_SCALE: out_sample_in = clamped;
         default:             out_sample_in = 16'sd0;
      endcase
   end

   assign out_valid_in = adv_out ? mul_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (adv_mul) begin
         mul_ff <= mul_in;
      end
      if (adv_out && mul_valid_ff) begin
         out_sample_ff <= out_sample_in;
         out_last_ff   <= mul_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_last_out   = out_last_ff;

endmodule

// ===== sv/dithered_q15_gain_apply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dithered_q15_gain_apply
// Applies a Q15 gain to signed 16-bit PCM samples with optional TPDF dither.
// ----------------------------------------------------------------------------
// The block takes one item per clock while req_stall is low and returns one
// result per item, in order. An accepted item passes through the two-entry
// queue, the multiplier register and the output register; dither is added
// to the product, and the sum is shifted and saturated into the output
// register. The front end runs the noise generator (two xorshift32 steps per
// scaled item while dither is on) in the accept cycle, so dither is drawn in
// item order however the output stalls. A gain of zero gives silence and a
// gain at or above unity passes the sample through; neither draws dither.
// The dither enable resets to on. The user must write it through the csr port
// only while the block is idle; the block itself does not enforce this.
module dithered_q15_gain_apply (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_sample_in,
   input  logic [15:0]         req_gain,
   input  logic                req_last_in_buffer,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_sample_out,
   output logic                rsp_last_out
);

   logic                                push;
   logic                                pop;
   logic                                q_empty;
   logic                                q_full;
   logic [dqg_pkg::QUEUE_CNT_W-1:0]     q_count;
   dqg_pkg::entry_type                  front_entry;
   dqg_pkg::entry_type                  head_entry;

   assign req_stall = q_full;
   assign push      = req_valid && !req_stall;

   dqg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .push           (push),
      .sample_in      (req_sample_in),
      .gain           (req_gain),
      .last_in_buffer (req_last_in_buffer),
      .entry          (front_entry)
   );

   dqg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (q_empty),
      .full       (q_full),
      .count      (q_count)
   );

   dqg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (!q_empty),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_last_out   (rsp_last_out)
   );

   // The back end never takes an item from an empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("item popped from empty queue");

   // Queue occupancy only moves with a push or a pop.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (push == pop) |=> $stable(q_count))
      else $error("queue count changed without net push or pop");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (q_count == $past(q_count) + 1'b1))
      else $error("queue count did not follow a push");

   // An item still in the queue stays there until the back end pops it.
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (!q_empty && !pop) |=> !q_empty)
      else $error("queued item lost");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dithered Q15 gain block. A short table of
// directed items covers mute, unity, gains above unity, full-scale samples
// and both dither settings. Random items then follow in bursts while the
// output side stalls in changing patterns. Every result is compared in order
// against a local model of the gain, the xorshift noise source and the
// requantizer.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
   } scaled_type;

   typedef enum logic {ROW_ITEM, ROW_DITHER_WR} row_kind_type;

   // For a dither write row, the last flag carries the new enable value.
   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  sample;
      logic [15:0]  gain;
      logic         last;
      logic         known;
      logic [15:0]  known_out;
   } dir_row_type;

   localparam int N_DIR = 22;
   localparam int ITEMS_PER_PHASE = 400;

   dir_row_type dir_rows [N_DIR] = '{
      '{ROW_ITEM,      16'h04D2, 16'h0000, 1'b0, 1'b1, 16'h0000},
      '{ROW_ITEM,      16'h8000, 16'h8000, 1'b1, 1'b1, 16'h8000},
      '{ROW_ITEM,      16'h7FFF, 16'h8000, 1'b0, 1'b1, 16'h7FFF},
      '{ROW_ITEM,      16'h5A5A, 16'hFFFF, 1'b1, 1'b1, 16'h5A5A},
      '{ROW_ITEM,      16'hA5A5, 16'h8001, 1'b0, 1'b1, 16'hA5A5},
      '{ROW_ITEM,      16'h8000, 16'h0000, 1'b1, 1'b1, 16'h0000},
      '{ROW_ITEM,      16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'h8000, 16'h0001, 1'b0, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'h7FFF, 16'h0001, 1'b1, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'h0000, 16'h4000, 1'b0, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'hFFFF, 16'h4000, 1'b1, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'h3039, 16'h5555, 1'b0, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'hCFC6, 16'h2AAA, 1'b1, 1'b0, 16'h0000},
      '{ROW_DITHER_WR, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'hFFFF, 16'h0001, 1'b0, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'h0001, 16'h0001, 1'b1, 1'b0, 16'h0000},
      '{ROW_ITEM,      16'h1234, 16'h0000, 1'b0, 1'b1, 16'h0000},
      '{ROW_ITEM,      16'h8000, 16'h8000, 1'b1, 1'b1, 16'h8000},
      '{ROW_DITHER_WR, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic               csr_wr_data = 1'b0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_sample_in = '0;
   logic [15:0]        req_gain = '0;
   logic               req_last_in_buffer = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic               rsp_last_out;

   // Typed-in expectation that travels with the item currently offered.
   logic               known_pending = 1'b0;
   logic [15:0]        known_value = '0;

   logic [31:0]        noise_reg = dqg_pkg::NOISE_SEED;
   logic               dither_on = 1'b1;
   scaled_type         awaited_q [$];
   int                 error_count = 0;

   int                 stall_mode = 0;
   int                 stall_left = 0;
   int                 stall_tick = 0;

   dithered_q15_gain_apply u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_in      (req_sample_in),
      .req_gain           (req_gain),
      .req_last_in_buffer (req_last_in_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_last_out       (rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] noise_step(input logic [31:0] x);
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

   // Scales one sample and advances the noise source only when dither is drawn.
   function automatic logic signed [15:0] scale_sample(input logic signed [15:0] s,
                                                       input logic [15:0] g);
      longint      acc;
      logic [31:0] r1;
      logic [31:0] r2;
      if (g == 16'd0) return 16'sd0;
      if (g >= dqg_pkg::UNITY_GAIN) return s;
      acc = longint'(s) * longint'(g);
      if (dither_on) begin
         r1 = noise_step(noise_reg);
         r2 = noise_step(r1);
         noise_reg = r2;
         acc = acc + longint'(r1[14:0]) + longint'(r2[14:0]) - 64'sd32767;
      end
      acc = acc >>> 15;
      if (acc > 64'sd32767) acc = 64'sd32767;
      else if (acc < -64'sd32768) acc = -64'sd32768;
      return acc[15:0];
   endfunction

   always @(posedge clock) begin
      scaled_type want;
      if (reset) begin
         noise_reg = dqg_pkg::NOISE_SEED;
         dither_on = 1'b1;
         awaited_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_q.size() == 0) begin
               $error("result with no item outstanding: sample_out %0d", rsp_sample_out);
               error_count++;
            end else begin
               want = awaited_q.pop_front();
               if (rsp_sample_out !== want.sample) begin
                  $error("sample_out mismatch: expected %0d, got %0d",
                         want.sample, rsp_sample_out);
                  error_count++;
               end
               if (rsp_last_out !== want.last) begin
                  $error("last_out mismatch: expected %0d, got %0d",
                         want.last, rsp_last_out);
                  error_count++;
               end
            end
         end
         if (csr_wr_en) dither_on = csr_wr_data;
         if (req_valid && !req_stall) begin
            want.sample = scale_sample(req_sample_in, req_gain);
            if (known_pending) want.sample = known_value;
            want.last = req_last_in_buffer;
            awaited_q.push_back(want);
         end
      end
   end

   // The receiver switches between free flow, random, periodic and heavy stalls.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      stall_tick++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= ((stall_tick % 7) < 3);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   task automatic send_item(input logic [15:0] s, input logic [15:0] g, input logic l,
                            input logic has_known, input logic [15:0] kv);
      req_valid = 1'b1;
      req_sample_in = s;
      req_gain = g;
      req_last_in_buffer = l;
      known_pending = has_known;
      known_value = kv;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int n);
      req_valid = 1'b0;
      known_pending = 1'b0;
      repeat (n) begin
         req_sample_in = 16'($urandom);
         req_gain = 16'($urandom);
         req_last_in_buffer = 1'($urandom);
         @(negedge clock);
      end
   endtask

   task automatic wait_drain;
      req_valid = 1'b0;
      known_pending = 1'b0;
      while (awaited_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_dither(input logic v);
      wait_drain();
      // Every item yields a result, so the queue and both back-end registers are
      // empty here; the extra wait before the write is only a margin.
      repeat (4) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      int          sent;
      int          burst;
      logic [15:0] s;
      logic [15:0] g;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         if (dir_rows[i].kind == ROW_DITHER_WR) begin
            write_dither(dir_rows[i].last);
         end else begin
            send_item(dir_rows[i].sample, dir_rows[i].gain, dir_rows[i].last,
                      dir_rows[i].known, dir_rows[i].known_out);
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         write_dither(phase % 2 == 1);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < ITEMS_PER_PHASE) begin
               case ($urandom_range(0, 9))
                  0: s = 16'h8000;
                  1: s = 16'h7FFF;
                  2: s = 16'($urandom_range(0, 16) - 8);
                  default: s = 16'($urandom);
               endcase
               case ($urandom_range(0, 19))
                  0: g = 16'd0;
                  1: g = dqg_pkg::UNITY_GAIN;
                  2: g = 16'($urandom_range(32769, 65535));
                  3: g = 16'h7FFF;
                  4: g = 16'($urandom_range(1, 16));
                  default: g = 16'($urandom_range(1, 32767));
               endcase
               send_item(s, g, 1'($urandom_range(0, 1)), 1'b0, 16'h0000);
               sent++;
               burst--;
               // Hold off in mid phase until the block has emptied completely.
               if (phase == 2 && sent == ITEMS_PER_PHASE / 2) wait_drain();
            end
            // The last phase streams with no gaps on the sending side.
            if (phase != 3 && $urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
         end
      end

      wait_drain();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("** dithered_q15_gain_apply: PASSED **");
      end else begin
         $display("** dithered_q15_gain_apply: FAILED **");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("** dithered_q15_gain_apply: FAILED **");
      $finish;
   end

endmodule
